// File: design/gnss_calendar_time_converter_macros.svh
// ----------------------------------------------------------------------------
// gnss calendar time converter assertion macros
// shared concurrent assertion forms, clocked on clk_i with reset rst_ni
// ----------------------------------------------------------------------------
`ifndef GNSS_CALENDAR_TIME_CONVERTER_MACROS_SVH
`define GNSS_CALENDAR_TIME_CONVERTER_MACROS_SVH

// same-cycle implication
`define GCTC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gctc_pkg.sv
// ----------------------------------------------------------------------------
// gctc_pkg
// types, constants and tables of the gnss calendar time converter
// ----------------------------------------------------------------------------
`default_nettype none

package gctc_pkg;

  localparam int WEEK_BITS = 13;

  localparam logic [39:0] US_PER_WEEK = 40'd604800000000;
  localparam logic [36:0] US_PER_DAY  = 37'd86400000000;
  localparam logic [31:0] US_PER_HOUR = 32'd3600000000;
  localparam logic [25:0] US_PER_MIN  = 26'd60000000;
  localparam logic [36:0] BDS_LEAP_US = 37'd14000000;

  localparam int BDS_DAYS      = 9492;
  localparam int GPS_EPOCH_MJD = 44244;
  localparam int MJD_DAYS_MAX  = 131071 - GPS_EPOCH_MJD;
  localparam int MJD_DAY_OFS   = 679019 + GPS_EPOCH_MJD;
  localparam int CAL_B_OFS     = GPS_EPOCH_MJD + 2400001 + 1537;
  localparam int CAL_X_OFS     = 100 * CAL_B_OFS - 12210;
  localparam int YEAR_BASE     = 4715;

  // exact reciprocals: shift = operand bits + ceil(log2 divisor)
  localparam int CENT_SH = 44;
  localparam longint unsigned CENT_MUL = ((64'd1 << CENT_SH) + 64'd36524) / 64'd36525;
  localparam int MON_SH = 43;
  localparam longint unsigned MON_MUL = ((64'd1 << MON_SH) + 64'd306000) / 64'd306001;
  localparam int HOUR_SH = 49;
  localparam longint unsigned HOUR_MUL = ((64'd1 << HOUR_SH) + 64'd3515624) / 64'd3515625;
  localparam int MIN_SH = 42;
  localparam longint unsigned MIN_MUL = ((64'd1 << MIN_SH) + 64'd234374) / 64'd234375;
  localparam int SEVEN_SH = 23;
  localparam longint unsigned SEVEN_MUL = ((64'd1 << SEVEN_SH) + 64'd6) / 64'd7;

  typedef struct packed {
    logic        kind;
    logic        use_bds;
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [25:0] cal_micros;
    logic [12:0] week_in;
    logic [39:0] week_micros_in;
  } in_item_t;

  typedef struct packed {
    logic [19:0] sel_days;
    logic [36:0] sel_sod;
    logic [16:0] gps_days;
    logic [36:0] gps_sod;
    logic        err;
  } front_out_t;

  typedef struct packed {
    logic [12:0] week;
    logic [39:0] sow;
    logic        err;
  } week_res_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [25:0] micros;
  } tod_res_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [16:0] mjd;
  } cal_res_t;

  // floor(30.6001 * e)
  function automatic logic [8:0] jd_month_days(input logic [4:0] e);
    logic [8:0] r;
    case (e)
      5'd0:    r = 9'd0;
      5'd1:    r = 9'd30;
      5'd2:    r = 9'd61;
      5'd3:    r = 9'd91;
      5'd4:    r = 9'd122;
      5'd5:    r = 9'd153;
      5'd6:    r = 9'd183;
      5'd7:    r = 9'd214;
      5'd8:    r = 9'd244;
      5'd9:    r = 9'd275;
      5'd10:   r = 9'd306;
      5'd11:   r = 9'd336;
      5'd12:   r = 9'd367;
      5'd13:   r = 9'd397;
      5'd14:   r = 9'd428;
      5'd15:   r = 9'd459;
      5'd16:   r = 9'd489;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [39:0] day_us(input logic [2:0] k);
    return 40'(k) * 40'(US_PER_DAY);
  endfunction

endpackage

`default_nettype wire

// File: design/gnss_calendar_time_converter.sv
// ----------------------------------------------------------------------------
// gnss_calendar_time_converter
// calendar date and time to gps/bds week time and back, via the mjd
// ----------------------------------------------------------------------------
// usage:
//  s_axis carries one conversion request per item; tuser selects the kind
//  (calendar to week time, or week time to calendar) and the gps/bds scale.
//  m_axis returns one result per item: calendar, week time, mjd, and the
//  range flag in tuser; on a range error all tdata bits are zero.
//  throughput is one item per cycle unless the receiver stalls. the depth
//  is set by the day-count front end (3 stages), the mjd to date chain of
//  reciprocal multiplies (6 stages) and the output register.
//  reset empties the pipeline; no item is in flight after it.
//  when the receiver stalls with a result waiting, the whole pipeline holds
//  and s_axis_tready_o drops; bubbles move ahead while no result waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gnss_calendar_time_converter_macros.svh"

module gnss_calendar_time_converter import gctc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_micros,
  // week_in, week_micros_in, zero pad
  input  wire logic [111:0] s_axis_tdata_i,
  // kind, use_bds
  input  wire logic [1:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // out_year, out_month, out_day, out_hour, out_minute, out_micros,
  // week_out, week_micros_out, mjd_day
  output logic [127:0]      m_axis_tdata_o,
  // range_error
  output logic              m_axis_tuser_o
);

  logic       en;
  logic [9:0] v_q;
  in_item_t   item;
  front_out_t front;
  cal_res_t   cal;
  tod_res_t   tod;
  week_res_t  wk;
  logic [127:0] data_q;
  logic         err_q;

  assign en = !v_q[9] || m_axis_tready_i;

  always_comb begin
    item.kind           = s_axis_tuser_i[0];
    item.use_bds        = s_axis_tuser_i[1];
    item.cal_year       = s_axis_tdata_i[11:0];
    item.cal_month      = s_axis_tdata_i[15:12];
    item.cal_day        = s_axis_tdata_i[20:16];
    item.cal_hour       = s_axis_tdata_i[25:21];
    item.cal_minute     = s_axis_tdata_i[31:26];
    item.cal_micros     = s_axis_tdata_i[57:32];
    item.week_in        = s_axis_tdata_i[70:58];
    item.week_micros_in = s_axis_tdata_i[110:71];
  end

  gctc_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .item_i (item),
    .res_o  (front)
  );

  gctc_cal u_cal (
    .clk_i  (clk_i),
    .en_i   (en),
    .days_i (front.gps_days),
    .res_o  (cal)
  );

  gctc_tod u_tod (
    .clk_i (clk_i),
    .en_i  (en),
    .sod_i (front.gps_sod),
    .res_o (tod)
  );

  gctc_week u_week (
    .clk_i  (clk_i),
    .en_i   (en),
    .days_i (front.sel_days),
    .sod_i  (front.sel_sod),
    .err_i  (front.err),
    .res_o  (wk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[8:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_q <= wk.err;
      if (wk.err) begin
        data_q <= '0;
      end else begin
        data_q <= {cal.mjd, wk.sow, wk.week, tod.micros, tod.minute, tod.hour,
                   cal.day, cal.month, cal.year};
      end
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = v_q[9];
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = err_q;

  `GCTC_ASSERT_IMP(a_err_zero, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == 128'd0, "range error with nonzero result")
  `GCTC_ASSERT_IMP(a_sow_range, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o[110:71] < US_PER_WEEK, "micros of week out of range")
  `GCTC_ASSERT_IMP(a_tod_range, m_axis_tvalid_o && !m_axis_tuser_o, (m_axis_tdata_o[25:21] < 5'd24) && (m_axis_tdata_o[31:26] < 6'd60) && (m_axis_tdata_o[57:32] < US_PER_MIN), "time of day out of range")
  `GCTC_ASSERT_NEXT(a_stall_hold, m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o || m_axis_tready_i, "pipeline advanced under stall")

endmodule

`default_nettype wire

// File: design/gctc_front.sv
// ----------------------------------------------------------------------------
// gctc_front
// three stages: both request kinds reduced to day counts and micros of day
// ----------------------------------------------------------------------------
`default_nettype none

module gctc_front import gctc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       en_i,
  input  wire in_item_t   item_i,
  output front_out_t      res_o
);

  // stage 1
  logic               kind_q, bds_q;
  logic signed [23:0] yterm_q;
  logic [4:0]         mp1_q, dd_q;
  logic [36:0]        tod_q;
  logic [39:0]        sow1_q;
  logic [13:0]        week1_q;

  logic               le2;
  logic signed [12:0] y_adj;
  logic [3:0]         m_adj;
  logic               wc;

  always_comb begin
    le2   = item_i.cal_month <= 4'd2;
    y_adj = $signed({1'b0, item_i.cal_year}) - (le2 ? 13'sd1 : 13'sd0);
    m_adj = le2 ? item_i.cal_month + 4'd12 : item_i.cal_month;
    wc    = item_i.week_micros_in >= US_PER_WEEK;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q  <= item_i.kind;
      bds_q   <= item_i.use_bds;
      yterm_q <= (24'(y_adj) * 24'sd1461) >>> 2;
      mp1_q   <= 5'(m_adj) + 5'd1;
      dd_q    <= item_i.cal_day;
      tod_q   <= 37'(item_i.cal_hour) * 37'(US_PER_HOUR)
               + 37'(item_i.cal_minute) * 37'(US_PER_MIN)
               + 37'(item_i.cal_micros);
      sow1_q  <= wc ? item_i.week_micros_in - US_PER_WEEK : item_i.week_micros_in;
      week1_q <= 14'(item_i.week_in) + (wc ? 14'd1 : 14'd0);
    end
  end

  // stage 2
  logic               kind2_q, bds2_q;
  logic signed [23:0] d2_q;
  logic [36:0]        sod2_q;

  logic               tc;
  logic signed [23:0] d0;
  logic [2:0]         k1;
  logic [16:0]        ds1;

  always_comb begin
    tc = tod_q >= US_PER_DAY;
    d0 = yterm_q + $signed({15'b0, jd_month_days(mp1_q)}) + $signed({19'b0, dd_q})
       - 24'(MJD_DAY_OFS) + (tc ? 24'sd1 : 24'sd0);
    k1 = 3'd0;
    for (int j = 1; j < 7; j++) begin
      if (sow1_q >= day_us(3'(j))) k1 = 3'(j);
    end
    ds1 = (17'(week1_q) << 3) - 17'(week1_q) + 17'(k1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind2_q <= kind_q;
      bds2_q  <= bds_q;
      if (!kind_q) begin
        d2_q   <= d0;
        sod2_q <= tc ? tod_q - US_PER_DAY : tod_q;
      end else begin
        d2_q   <= $signed({7'b0, ds1});
        sod2_q <= 37'(sow1_q - day_us(k1));
      end
    end
  end

  // stage 3
  front_out_t         res_q;
  logic signed [23:0] ds_s, dg_s;
  logic [36:0]        sel_sod, gps_sod;
  logic [37:0]        g;
  logic               br, cy, neg;

  always_comb begin
    ds_s    = d2_q;
    dg_s    = d2_q;
    sel_sod = sod2_q;
    gps_sod = sod2_q;
    br      = sod2_q < BDS_LEAP_US;
    g       = 38'(sod2_q) + 38'(BDS_LEAP_US);
    cy      = g >= 38'(US_PER_DAY);
    neg     = 1'b0;
    if (!kind2_q) begin
      if (bds2_q) begin
        sel_sod = br ? sod2_q + US_PER_DAY - BDS_LEAP_US : sod2_q - BDS_LEAP_US;
        ds_s    = d2_q - 24'(BDS_DAYS) - (br ? 24'sd1 : 24'sd0);
      end
      neg = d2_q[23] | ds_s[23];
    end else if (bds2_q) begin
      gps_sod = cy ? 37'(g - 38'(US_PER_DAY)) : 37'(g);
      dg_s    = d2_q + 24'(BDS_DAYS) + (cy ? 24'sd1 : 24'sd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.sel_days <= 20'(ds_s);
      res_q.sel_sod  <= sel_sod;
      res_q.gps_days <= 17'(dg_s);
      res_q.gps_sod  <= gps_sod;
      res_q.err      <= neg | (dg_s > 24'(MJD_DAYS_MAX));
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// File: design/gctc_cal.sv
// ----------------------------------------------------------------------------
// gctc_cal
// six stages: modified julian day to calendar date
// ----------------------------------------------------------------------------
`default_nettype none

module gctc_cal import gctc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [16:0] days_i,
  output cal_res_t         res_o
);

  logic [27:0] x_q;
  logic [21:0] b1_q, b2_q;
  logic [16:0] mjd_q [5];
  logic [12:0] c2_q, c3_q, c4_q, c5_q;
  logic [9:0]  bmd3_q, bmd4_q, bmd5_q;
  logic [23:0] x2_q;
  logic [4:0]  e_q;
  cal_res_t    res_q;

  logic [56:0] prod_c;
  logic [48:0] prod_e;
  logic [21:0] dd;
  logic [3:0]  mon;

  always_comb begin
    prod_c = 57'(x_q) * 57'(CENT_MUL);
    dd     = 22'((24'(c2_q) * 24'd1461) >> 2);
    prod_e = 49'(x2_q) * 49'(MON_MUL);
    mon    = 4'(e_q - 5'd1 - ((e_q >= 5'd14) ? 5'd12 : 5'd0));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q      <= 28'(28'(days_i) * 28'd100 + 28'(CAL_X_OFS));
      b1_q     <= 22'(days_i) + 22'(CAL_B_OFS);
      mjd_q[0] <= days_i + 17'(GPS_EPOCH_MJD);
      c2_q     <= prod_c[CENT_SH +: 13];
      b2_q     <= b1_q;
      mjd_q[1] <= mjd_q[0];
      bmd3_q   <= 10'(b2_q - dd);
      c3_q     <= c2_q;
      mjd_q[2] <= mjd_q[1];
      x2_q     <= 24'(bmd3_q) * 24'd10000;
      bmd4_q   <= bmd3_q;
      c4_q     <= c3_q;
      mjd_q[3] <= mjd_q[2];
      e_q      <= prod_e[MON_SH +: 5];
      bmd5_q   <= bmd4_q;
      c5_q     <= c4_q;
      mjd_q[4] <= mjd_q[3];
      res_q.day   <= 5'(bmd5_q - 10'(jd_month_days(e_q)));
      res_q.month <= mon;
      res_q.year  <= 12'(c5_q - 13'(YEAR_BASE) - ((mon >= 4'd3) ? 13'd1 : 13'd0));
      res_q.mjd   <= mjd_q[4];
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// File: design/gctc_tod.sv
// ----------------------------------------------------------------------------
// gctc_tod
// six stages: micros of day split into hour, minute and micros of minute
// ----------------------------------------------------------------------------
`default_nettype none

module gctc_tod import gctc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [36:0] sod_i,
  output tod_res_t         res_o
);

  logic [36:0] sod1_q;
  logic [4:0]  h1_q, h2_q, h3_q;
  logic [31:0] remh2_q, remh3_q;
  logic [5:0]  mn3_q;
  tod_res_t    res_q [3];

  logic [54:0] prod_h;
  logic [48:0] prod_m;

  always_comb begin
    prod_h = 55'(sod_i[36:10]) * 55'(HOUR_MUL);
    prod_m = 49'(remh2_q[31:8]) * 49'(MIN_MUL);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h1_q    <= prod_h[HOUR_SH +: 5];
      sod1_q  <= sod_i;
      remh2_q <= 32'(sod1_q - 37'(h1_q) * 37'(US_PER_HOUR));
      h2_q    <= h1_q;
      mn3_q   <= prod_m[MIN_SH +: 6];
      remh3_q <= remh2_q;
      h3_q    <= h2_q;
      res_q[0].hour   <= h3_q;
      res_q[0].minute <= mn3_q;
      res_q[0].micros <= 26'(remh3_q - 32'(mn3_q) * 32'(US_PER_MIN));
      res_q[1] <= res_q[0];
      res_q[2] <= res_q[1];
    end
  end

  assign res_o = res_q[2];

endmodule

`default_nettype wire

// File: design/gctc_week.sv
// ----------------------------------------------------------------------------
// gctc_week
// six stages: selected-scale day count to week and micros of week
// ----------------------------------------------------------------------------
`default_nettype none

module gctc_week import gctc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [19:0] days_i,
  input  wire logic [36:0] sod_i,
  input  wire logic        err_i,
  output week_res_t        res_o
);

  logic [19:0] ds1_q;
  logic [36:0] sod1_q, sod2_q;
  logic [17:0] q1_q, q2_q;
  logic [2:0]  k2_q;
  logic        err1_q, err2_q;
  week_res_t   res_q [4];

  logic [40:0] prod;

  assign prod = 41'(days_i) * 41'(SEVEN_MUL);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_q   <= prod[SEVEN_SH +: 18];
      ds1_q  <= days_i;
      sod1_q <= sod_i;
      err1_q <= err_i;
      k2_q   <= 3'(21'(ds1_q) - (21'(q1_q) << 3) + 21'(q1_q));
      q2_q   <= q1_q;
      sod2_q <= sod1_q;
      err2_q <= err1_q;
      res_q[0].week <= 13'(q2_q);
      res_q[0].sow  <= day_us(k2_q) + 40'(sod2_q);
      res_q[0].err  <= err2_q | ((q2_q >> WEEK_BITS) != 18'd0);
      res_q[1] <= res_q[0];
      res_q[2] <= res_q[1];
      res_q[3] <= res_q[2];
    end
  end

  assign res_o = res_q[3];

endmodule

`default_nettype wire
